// ----- src/wdb_pkg.sv -----
// ============================================================================
// wdb_pkg
// Shared types and constants for the watchdog bank: operation codes,
// sequencer states, per-slot status record and the run hysteresis limit.
// ============================================================================
package wdb_pkg;

    // Fixed field widths of the item channels
    localparam int OP_W       = 2;
    localparam int IDX_W      = 3;
    localparam int IN_COUNT_W = 16;
    localparam int MASK_W     = 8;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_SLOTS   = 8;
    localparam int DEF_COUNT_WIDTH = 16;

    // Run counters saturate at the hysteresis limit
    localparam int             RUN_W     = 4;
    localparam logic [RUN_W-1:0] RUN_LIMIT = 4'd10;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER = 2'd0,
        OP_FEED     = 2'd1,
        OP_TICK     = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_TICK,
        S_DONE
    } t_state;

    // Per-slot status, apart from the countdown itself
    typedef struct packed {
        logic [RUN_W-1:0] on_run;
        logic [RUN_W-1:0] off_run;
        logic             handler;
        logic             online;
        logic             offline;
    } t_slot_st;

endpackage

// ----- src/wdb_if.sv -----
// ============================================================================
// wdb_if
// Item channels of the watchdog bank: command items in, status items out.
// ============================================================================
interface wdb_in_if;
    import wdb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [IDX_W-1:0]      instance_index;
    logic [IN_COUNT_W-1:0] reload_value;
    logic [IN_COUNT_W-1:0] initial_count;
    logic                  has_handler;

    modport source (
        output valid, operation, instance_index, reload_value, initial_count,
               has_handler,
        input  ready
    );
    modport sink (
        input  valid, operation, instance_index, reload_value, initial_count,
               has_handler,
        output ready
    );
endinterface

interface wdb_out_if;
    import wdb_pkg::*;

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] alarm_mask;
    logic [MASK_W-1:0] online_mask;
    logic [MASK_W-1:0] offline_mask;
    logic [IDX_W-1:0]  assigned_index;
    logic              register_rejected;

    modport source (
        output valid, alarm_mask, online_mask, offline_mask, assigned_index,
               register_rejected,
        input  ready
    );
    modport sink (
        input  valid, alarm_mask, online_mask, offline_mask, assigned_index,
               register_rejected,
        output ready
    );
endinterface

// ----- src/watchdog_bank_with_hysteresis.sv -----
// ============================================================================
// watchdog_bank_with_hysteresis
// Bank of watchdog slots with hysteresis on the online/offline flags. Slot
// words live in a small memory; a tick walks the registered slots through
// one shared update unit.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-----------------------------------------
//   i_in     | in  | valid/ready   | operation, index, reload, count, handler
//   o_out    | out | valid/ready   | alarm/online/offline masks, slot, reject
//
// Register and no-op items, a feed to an unregistered slot and a tick with no
// slots go from accept straight to finish. Another feed passes a state that
// writes the slot word back with its countdown reloaded; another tick walks the
// registered slots in turn through the memory read port and the update unit. A
// new item is accepted while the previous result waits in the output register.
// Reset clears the fill count, the flags and the handshake; slot memory needs
// no clearing as only slots below the fill count are used. A stalled output
// holds the sequencer in its finish state until the output register frees up.
// ============================================================================
module watchdog_bank_with_hysteresis #(
    parameter int MAX_SLOTS   = wdb_pkg::DEF_MAX_SLOTS,
    parameter int COUNT_WIDTH = wdb_pkg::DEF_COUNT_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wdb_in_if.sink     i_in,
    wdb_out_if.source  o_out
);
    import wdb_pkg::*;

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int ST_W   = 2 * RUN_W + 1;
    localparam int WORD_W = 2 * COUNT_WIDTH + ST_W;

    // Sequencer and bookkeeping
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_reg_cnt, n_reg_cnt;
    logic [SLOT_W-1:0]      r_ptr, n_ptr;
    logic [MASK_W-1:0]      r_alarm, n_alarm;
    logic [IDX_W-1:0]       r_assigned, n_assigned;
    logic                   r_rejected, n_rejected;
    logic [MAX_SLOTS-1:0]   r_online, n_online;
    logic [MAX_SLOTS-1:0]   r_offline, n_offline;

    // Output register
    logic                   r_out_valid;
    logic [MASK_W-1:0]      r_out_alarm;
    logic [MASK_W-1:0]      r_out_online;
    logic [MASK_W-1:0]      r_out_offline;
    logic [IDX_W-1:0]       r_out_assigned;
    logic                   r_out_rejected;

    // Slot memory: {reload, count, on_run, off_run, handler}
    logic [WORD_W-1:0]      mem [MAX_SLOTS];
    logic [WORD_W-1:0]      r_rd_word;
    logic                   mem_we;
    logic [SLOT_W-1:0]      mem_waddr;
    logic [SLOT_W-1:0]      mem_raddr;
    logic [WORD_W-1:0]      mem_wdata;

    // Fields of the word read last cycle
    logic [COUNT_WIDTH-1:0] rd_reload;
    logic [COUNT_WIDTH-1:0] rd_count;
    logic [RUN_W-1:0]       rd_on_run;
    logic [RUN_W-1:0]       rd_off_run;
    logic                   rd_handler;

    // Shared update unit
    t_slot_st               tu_in_st, tu_out_st;
    logic [COUNT_WIDTH-1:0] tu_out_count;
    logic                   tu_alarm;

    logic                   accept;
    logic                   done_load;
    logic                   tick_last;
    logic                   feed_ok;
    logic [MASK_W-1:0]      online_mask;
    logic [MASK_W-1:0]      offline_mask;
    t_op                    in_op;

    assign in_op     = t_op'(i_in.operation);
    assign accept    = i_in.valid && i_in.ready;
    assign done_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    assign tick_last = (32'(r_ptr) + 1) == 32'(r_reg_cnt);
    assign feed_ok   = 32'(i_in.instance_index) < 32'(r_reg_cnt);

    assign i_in.ready = (r_state == S_IDLE);

    assign {rd_reload, rd_count, rd_on_run, rd_off_run, rd_handler} = r_rd_word;

    assign tu_in_st = '{on_run:  rd_on_run,
                        off_run: rd_off_run,
                        handler: rd_handler,
                        online:  r_online[r_ptr],
                        offline: r_offline[r_ptr]};

    wdb_tick_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tick (
        .i_count (rd_count),
        .i_st    (tu_in_st),
        .o_count (tu_out_count),
        .o_st    (tu_out_st),
        .o_alarm (tu_alarm)
    );

    // Low eight slots feed the masks
    for (genvar g = 0; g < MASK_W; g++) begin : g_mask
        if (g < MAX_SLOTS) begin : g_on
            assign online_mask[g]  = r_online[g];
            assign offline_mask[g] = r_offline[g];
        end else begin : g_off
            assign online_mask[g]  = 1'b0;
            assign offline_mask[g] = 1'b0;
        end
    end

    // Next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (in_op == OP_FEED && feed_ok) begin
                        n_state = S_FEED;
                    end else if (in_op == OP_TICK && r_reg_cnt != '0) begin
                        n_state = S_TICK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FEED: n_state = S_DONE;
            S_TICK: begin
                if (tick_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (done_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_reg_cnt  = r_reg_cnt;
        n_ptr      = r_ptr;
        n_alarm    = r_alarm;
        n_assigned = r_assigned;
        n_rejected = r_rejected;
        n_online   = r_online;
        n_offline  = r_offline;
        mem_we     = 1'b0;
        mem_waddr  = r_ptr;
        mem_raddr  = r_ptr;
        mem_wdata  = r_rd_word;
        unique case (r_state)
            S_IDLE: begin
                mem_raddr = SLOT_W'(i_in.instance_index);
                if (accept) begin
                    n_alarm    = '0;
                    n_assigned = '0;
                    n_rejected = 1'b0;
                    unique case (in_op)
                        OP_REGISTER: begin
                            if (32'(r_reg_cnt) < MAX_SLOTS) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_reg_cnt[SLOT_W-1:0];
                                mem_wdata = {COUNT_WIDTH'(i_in.reload_value),
                                             COUNT_WIDTH'(i_in.initial_count),
                                             {RUN_W{1'b0}}, {RUN_W{1'b0}},
                                             i_in.has_handler};
                                n_online[r_reg_cnt[SLOT_W-1:0]]  = 1'b0;
                                n_offline[r_reg_cnt[SLOT_W-1:0]] = 1'b0;
                                n_assigned = IDX_W'(r_reg_cnt);
                                n_reg_cnt  = r_reg_cnt + 1'b1;
                            end else begin
                                n_rejected = 1'b1;
                            end
                        end
                        OP_FEED: begin
                            n_ptr = SLOT_W'(i_in.instance_index);
                        end
                        OP_TICK: begin
                            mem_raddr = '0;
                            n_ptr     = '0;
                        end
                        OP_NONE: begin
                            n_ptr = r_ptr;
                        end
                        default: n_ptr = r_ptr;
                    endcase
                end
            end
            // Reload the countdown of the fed slot
            S_FEED: begin
                mem_we    = 1'b1;
                mem_wdata = {rd_reload, rd_reload, rd_on_run, rd_off_run, rd_handler};
            end
            // Update the slot read last cycle, read the next one
            S_TICK: begin
                mem_we    = 1'b1;
                mem_wdata = {rd_reload, tu_out_count, tu_out_st.on_run,
                             tu_out_st.off_run, rd_handler};
                n_online[r_ptr]  = tu_out_st.online;
                n_offline[r_ptr] = tu_out_st.offline;
                for (int i = 0; i < MASK_W; i++) begin
                    if (i < MAX_SLOTS && 32'(r_ptr) == i && tu_alarm) begin
                        n_alarm[i] = 1'b1;
                    end
                end
                mem_raddr = r_ptr + 1'b1;
                n_ptr     = r_ptr + 1'b1;
            end
            S_DONE: begin
                mem_we = 1'b0;
            end
            default: mem_we = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_reg_cnt   <= '0;
            r_online    <= '0;
            r_offline   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_reg_cnt <= n_reg_cnt;
            r_online  <= n_online;
            r_offline <= n_offline;
            if (done_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_alarm    <= n_alarm;
        r_assigned <= n_assigned;
        r_rejected <= n_rejected;
        if (done_load) begin
            r_out_alarm    <= r_alarm;
            r_out_online   <= online_mask;
            r_out_offline  <= offline_mask;
            r_out_assigned <= r_assigned;
            r_out_rejected <= r_rejected;
        end
    end

    // Slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_word <= mem[mem_raddr];
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.alarm_mask        = r_out_alarm;
    assign o_out.online_mask       = r_out_online;
    assign o_out.offline_mask      = r_out_offline;
    assign o_out.assigned_index    = r_out_assigned;
    assign o_out.register_rejected = r_out_rejected;

endmodule

// ----- src/wdb_tick_unit.sv -----
// ============================================================================
// wdb_tick_unit
// Shared per-slot tick update: countdown, run counters with saturation,
// online/offline hysteresis and the alarm decision for one slot.
// ============================================================================
module wdb_tick_unit #(
    parameter int COUNT_WIDTH = wdb_pkg::DEF_COUNT_WIDTH
) (
    input  logic [COUNT_WIDTH-1:0] i_count,
    input  wdb_pkg::t_slot_st      i_st,
    output logic [COUNT_WIDTH-1:0] o_count,
    output wdb_pkg::t_slot_st      o_st,
    output logic                   o_alarm
);
    import wdb_pkg::*;

    logic             live;
    logic [RUN_W-1:0] on_inc;
    logic [RUN_W-1:0] off_inc;

    assign live    = (i_count != '0);
    assign on_inc  = (i_st.on_run < RUN_LIMIT) ? i_st.on_run + 1'b1 : i_st.on_run;
    assign off_inc = (i_st.off_run < RUN_LIMIT) ? i_st.off_run + 1'b1 : i_st.off_run;

    // One slot, one tick
    always_comb begin
        o_st    = i_st;
        o_count = i_count;
        o_alarm = 1'b0;
        if (live) begin
            o_count    = i_count - 1'b1;
            o_st.off_run = '0;
            o_st.on_run  = on_inc;
            if (!i_st.online && on_inc >= RUN_LIMIT) begin
                o_st.online  = 1'b1;
                o_st.offline = 1'b0;
            end
        end else begin
            o_st.on_run  = '0;
            o_st.off_run = off_inc;
            if (!i_st.offline && off_inc >= RUN_LIMIT) begin
                o_st.offline = 1'b1;
                o_st.online  = 1'b0;
            end
            o_alarm = o_st.offline && i_st.handler;
        end
    end

endmodule
